/* rtl/twemp_pkg.sv */
// Package for the two-wheel encoder move controller.
// Holds item structs, register indexes, reset values and controller/datapath types.
// No dependencies.
package twemp_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WALK_SPEED = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TURN_SPEED = 3'd4;

    localparam logic [31:0] PROP_GAIN_RST  = 32'd3006477;
    localparam logic [31:0] INTEG_GAIN_RST = 32'd1718;
    localparam logic [31:0] DERIV_GAIN_RST = 32'd0;
    localparam logic [14:0] WALK_SPEED_RST = 15'd11469;
    localparam logic [14:0] TURN_SPEED_RST = 15'd8192;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;
    localparam logic MODE_WALK = 1'b0;
    localparam logic MODE_TURN = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic               move_mode;
        logic signed [31:0] goal_pulses;
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic [15:0]        elapsed_ms;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic               left_reached;
        logic               right_reached;
        logic               move_finished;
    } out_item_t;

    typedef enum logic [2:0] {
        MUL_INTEG = 3'd0,
        MUL_P_LO  = 3'd1,
        MUL_P_HI  = 3'd2,
        MUL_I_LO  = 3'd3,
        MUL_I_HI  = 3'd4,
        MUL_D_LO  = 3'd5,
        MUL_D_HI  = 3'd6
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     err_load;
        logic     acc_clr;
        logic     div_start;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     rate_load;
        logic     out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic pid_path;
        logic div_busy;
        logic out_free;
    } ctl_status_t;

endpackage

/* rtl/twemp_div.sv */
// Restoring divider, one quotient bit per cycle, signed dividend by unsigned divisor.
// Quotient truncates toward zero and saturates to signed 32 bit.
// No dependencies.
module twemp_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [32:0] dividend,
    input  logic [15:0]        divisor,
    output logic               busy,
    output logic signed [31:0] quotient
);

    localparam int NUM_W  = 33;
    localparam int DEN_W  = 16;
    localparam int STEP_W = $clog2(NUM_W + 1);
    localparam logic [STEP_W-1:0] STEPS = STEP_W'(NUM_W);

    logic [NUM_W-1:0]  work_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] cnt_reg;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W+1:0] trial;
    logic             fits;
    logic [NUM_W-1:0] mag_in;
    logic [31:0]      mag_neg;

    assign busy   = (cnt_reg != '0);
    assign rem_sh = {rem_reg, work_reg[NUM_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, den_reg};
    assign fits   = !trial[DEN_W+1];
    assign mag_in = dividend[32] ? (NUM_W'(0) - NUM_W'(dividend)) : NUM_W'(dividend);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= STEPS;
        end else if (busy) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= mag_in;
            rem_reg  <= '0;
            den_reg  <= divisor;
            neg_reg  <= dividend[32];
        end else if (busy) begin
            work_reg <= {work_reg[NUM_W-2:0], fits};
            rem_reg  <= fits ? trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign mag_neg = 32'd0 - work_reg[31:0];

    always_comb begin
        if (neg_reg) begin
            if (work_reg > 33'h080000000) begin
                quotient = 32'sh80000000;
            end else begin
                quotient = $signed(mag_neg);
            end
        end else begin
            if (work_reg[32] || work_reg[31]) begin
                quotient = 32'sh7FFFFFFF;
            end else begin
                quotient = $signed(work_reg[31:0]);
            end
        end
    end

endmodule

/* rtl/twemp_datapath.sv */
// Datapath: configuration registers, move state, PID arithmetic with one shared
// 17x32 multiplier, the divider and the output register.
// Depends on twemp_pkg and twemp_div.
module twemp_datapath import twemp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  in_item_t               s_data,
    input  logic                   m_ready,
    output logic                   m_valid,
    output out_item_t              m_data,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  ctl_cmd_t               cmd,
    output ctl_status_t            status
);

    logic [31:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [14:0] walk_speed_reg, turn_speed_reg;

    in_item_t           in_reg;
    logic signed [31:0] target_reg;
    logic               mode_reg;
    logic               left_done_reg, right_done_reg;
    logic signed [31:0] integ_reg, prev_err_reg, err_reg, rate_reg;
    logic signed [48:0] prod_reg;
    mul_sel_t           prod_sel_reg;
    logic               prod_vld_reg;
    logic signed [65:0] acc_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;

    logic signed [31:0] lc, rc, g;
    logic signed [32:0] lc33, rc33, ng, diff33;
    logic signed [31:0] err_next;
    logic signed [16:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [48:0] mul_p;
    logic signed [49:0] integ_sum;
    logic signed [31:0] integ_next;
    logic signed [65:0] prod_ext, acc_add;
    logic               prod_hi;
    logic signed [48:0] corr;
    logic signed [50:0] base, base_neg;
    logic signed [15:0] ws, ts;
    logic signed [15:0] ls, rs;
    logic               ld, rd, fin;
    logic               pid_path;
    logic               div_busy;
    logic signed [31:0] div_quo;

    function automatic logic signed [15:0] sat16(input logic signed [50:0] v);
        if (v > 51'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -51'sd32768) begin
            return 16'sh8000;
        end else begin
            return v[15:0];
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= PROP_GAIN_RST;
            integ_gain_reg <= INTEG_GAIN_RST;
            deriv_gain_reg <= DERIV_GAIN_RST;
            walk_speed_reg <= WALK_SPEED_RST;
            turn_speed_reg <= TURN_SPEED_RST;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_PROP_GAIN:  prop_gain_reg  <= cfg_wdata;
                REG_INTEG_GAIN: integ_gain_reg <= cfg_wdata;
                REG_DERIV_GAIN: deriv_gain_reg <= cfg_wdata;
                REG_WALK_SPEED: walk_speed_reg <= cfg_wdata[14:0];
                REG_TURN_SPEED: turn_speed_reg <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    assign lc   = in_reg.left_count;
    assign rc   = in_reg.right_count;
    assign g    = target_reg;
    assign lc33 = {lc[31], lc};
    assign rc33 = {rc[31], rc};
    assign ng   = -{g[31], g};

    assign diff33   = lc33 - rc33;
    assign err_next = (diff33[32] != diff33[31]) ?
                      (diff33[32] ? 32'sh80000000 : 32'sh7FFFFFFF) : diff33[31:0];

    assign pid_path = (in_reg.req_type == REQ_TICK) && !(left_done_reg && right_done_reg)
                      && (mode_reg == MODE_WALK);

    always_comb begin
        mul_a = {1'b0, prop_gain_reg[15:0]};
        mul_b = err_reg;
        case (cmd.mul_sel)
            MUL_INTEG: begin
                mul_a = {1'b0, in_reg.elapsed_ms};
                mul_b = err_reg;
            end
            MUL_P_LO: begin
                mul_a = {1'b0, prop_gain_reg[15:0]};
                mul_b = err_reg;
            end
            MUL_P_HI: begin
                mul_a = {1'b0, prop_gain_reg[31:16]};
                mul_b = err_reg;
            end
            MUL_I_LO: begin
                mul_a = {1'b0, integ_gain_reg[15:0]};
                mul_b = integ_reg;
            end
            MUL_I_HI: begin
                mul_a = {1'b0, integ_gain_reg[31:16]};
                mul_b = integ_reg;
            end
            MUL_D_LO: begin
                mul_a = {1'b0, deriv_gain_reg[15:0]};
                mul_b = rate_reg;
            end
            MUL_D_HI: begin
                mul_a = {1'b0, deriv_gain_reg[31:16]};
                mul_b = rate_reg;
            end
            default: begin
                mul_a = {1'b0, prop_gain_reg[15:0]};
                mul_b = err_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign integ_sum  = {{18{integ_reg[31]}}, integ_reg} + {prod_reg[48], prod_reg};
    assign integ_next = (integ_sum[49:31] == {19{integ_sum[31]}}) ? integ_sum[31:0] :
                        (integ_sum[49] ? 32'sh80000000 : 32'sh7FFFFFFF);

    always_comb begin
        prod_ext = {{17{prod_reg[48]}}, prod_reg};
        prod_hi  = prod_sel_reg inside {MUL_P_HI, MUL_I_HI, MUL_D_HI};
        acc_add  = prod_hi ? (prod_ext <<< 16) : prod_ext;
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg     <= mul_p;
            prod_sel_reg <= cmd.mul_sel;
        end
        if (cmd.capture) begin
            in_reg <= s_data;
        end
        if (cmd.err_load) begin
            err_reg <= err_next;
        end
        if (cmd.rate_load) begin
            rate_reg <= (in_reg.elapsed_ms == '0) ? 32'sd0 : div_quo;
        end
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (prod_vld_reg && (prod_sel_reg != MUL_INTEG)) begin
            acc_reg <= acc_reg + acc_add;
        end
        if (cmd.out_load) begin
            m_data_reg <= '{left_speed: ls, right_speed: rs, left_reached: ld,
                            right_reached: rd, move_finished: fin};
        end
    end

    twemp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend ({err_reg[31], err_reg} - {prev_err_reg[31], prev_err_reg}),
        .divisor  (in_reg.elapsed_ms),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    assign corr     = acc_reg[65:17];
    assign base     = $signed({36'd0, walk_speed_reg}) + {{2{corr[48]}}, corr};
    assign base_neg = -base;
    assign ws       = {1'b0, walk_speed_reg};
    assign ts       = {1'b0, turn_speed_reg};

    always_comb begin
        ls  = '0;
        rs  = '0;
        ld  = left_done_reg;
        rd  = right_done_reg;
        fin = 1'b0;
        if (in_reg.req_type == REQ_START) begin
            ld = 1'b0;
            rd = 1'b0;
            if (in_reg.move_mode == MODE_WALK) begin
                ls = ws;
                rs = ws;
            end
        end else if (left_done_reg && right_done_reg) begin
            fin = 1'b1;
        end else begin
            if (mode_reg == MODE_WALK) begin
                if (lc < g && g > 32'sd0) begin
                    ls = ws;
                end else if (lc > g && g < 32'sd0) begin
                    ls = -ws;
                end else begin
                    ld = 1'b1;
                end
                if (rc < g && g > 32'sd0) begin
                    rs = sat16(base);
                end else if (rc > g && g < 32'sd0) begin
                    rs = sat16(base_neg);
                end else begin
                    rd = 1'b1;
                end
            end else begin
                if (lc < g) begin
                    ls = ts;
                end else if (lc > g) begin
                    ls = -ts;
                end else begin
                    ld = 1'b1;
                end
                if (rc33 < ng) begin
                    rs = ts;
                end else if (rc33 > ng) begin
                    rs = -ts;
                end else begin
                    rd = 1'b1;
                end
            end
            if (ld && rd) begin
                fin = 1'b1;
                ls  = '0;
                rs  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg     <= '0;
            mode_reg       <= MODE_WALK;
            left_done_reg  <= 1'b1;
            right_done_reg <= 1'b1;
            integ_reg      <= '0;
            prev_err_reg   <= '0;
            prod_vld_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            prod_vld_reg <= cmd.mul_en;
            m_valid_reg  <= cmd.out_load || (m_valid_reg && !m_ready);
            if (prod_vld_reg && (prod_sel_reg == MUL_INTEG)) begin
                integ_reg <= integ_next;
            end
            if (cmd.out_load) begin
                left_done_reg  <= ld;
                right_done_reg <= rd;
                if (in_reg.req_type == REQ_START) begin
                    target_reg <= in_reg.goal_pulses;
                    mode_reg   <= in_reg.move_mode;
                end
                if (pid_path) begin
                    prev_err_reg <= err_reg;
                end
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;
    assign status.pid_path = pid_path;
    assign status.div_busy = div_busy;
    assign status.out_free = !m_valid_reg || m_ready;

endmodule

/* rtl/twemp_ctrl.sv */
// Controller: sequences capture, multiply steps, divider wait and result load.
// Depends on twemp_pkg.
module twemp_ctrl import twemp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  ctl_status_t status,
    output ctl_cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_EVAL     = 8'b0000_0010,
        ST_MAC      = 8'b0000_0100,
        ST_WAIT_DIV = 8'b0000_1000,
        ST_RATE     = 8'b0001_0000,
        ST_DMAC     = 8'b0010_0000,
        ST_DRAIN    = 8'b0100_0000,
        ST_OUT      = 8'b1000_0000
    } state_t;

    state_t   state_reg, state_next;
    mul_sel_t sel_reg, sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= MUL_INTEG;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.err_load = 1'b1;
                cmd.acc_clr  = 1'b1;
                sel_next     = MUL_INTEG;
                state_next   = status.pid_path ? ST_MAC : ST_OUT;
            end
            ST_MAC: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = sel_reg;
                cmd.div_start = (sel_reg == MUL_INTEG);
                if (sel_reg == MUL_I_HI) begin
                    state_next = ST_WAIT_DIV;
                end else begin
                    sel_next = mul_sel_t'(sel_reg + 3'd1);
                end
            end
            ST_WAIT_DIV: begin
                if (!status.div_busy) begin
                    state_next = ST_RATE;
                end
            end
            ST_RATE: begin
                cmd.rate_load = 1'b1;
                sel_next      = MUL_D_LO;
                state_next    = ST_DMAC;
            end
            ST_DMAC: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = sel_reg;
                if (sel_reg == MUL_D_HI) begin
                    state_next = ST_DRAIN;
                end else begin
                    sel_next = mul_sel_t'(sel_reg + 3'd1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/two_wheel_encoder_move_pid_unit.sv */
// Two-wheel encoder move controller with PID wheel synchronization, top level.
// Depends on twemp_pkg, twemp_ctrl and twemp_datapath.
//
// One item is in work at a time; every item gives one result. Start items and
// ticks outside a walk move pass from capture through evaluation to the result
// load. A walk-mode tick also waits on the 33-step restoring divider for the
// derivative term, while the integral update and the proportional and integral
// terms go through one shared 17x32 multiplier (16-bit gain halves) in the
// divider's shadow, followed by the two derivative steps. The result
// register lets a new item enter while the previous result waits for m_ready.
// Configuration writes take effect at once and are meant for idle periods.
module two_wheel_encoder_move_pid_unit import twemp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    ctl_cmd_t    cmd;
    ctl_status_t status;

    twemp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    twemp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item accepted while one is in work");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over a pending result");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");

    a_rate_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rate_load |-> !status.div_busy)
        else $error("rate taken before the divider finished");

endmodule

/* sim/two_wheel_move_checker.sv */
// Checker for the two-wheel encoder move controller: watches both item channels
// and the register write port, predicts each motor command and compares it.
// Depends on twemp_pkg.
module two_wheel_move_checker import twemp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  in_item_t               s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  out_item_t              m_data,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int                     mismatches,
    output int                     cmds_due,
    output int                     results_seen,
    output int                     moves_finished
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint S32_MAX = 2147483647;
    localparam longint S32_MIN = -S32_MAX - 1;
    localparam longint S16_MAX = 32767;
    localparam longint S16_MIN = -32768;

    logic [31:0]        p_gain, i_gain, d_gain;
    logic [14:0]        walk_spd, turn_spd;
    logic signed [31:0] integ_acc, last_err, goal_cnt;
    logic               run_mode, left_done, right_done;
    out_item_t          cmd_due_q[$];

    initial begin
        mismatches     = 0;
        cmds_due       = 0;
        results_seen   = 0;
        moves_finished = 0;
    end

    function automatic longint clamp(logic signed [67:0] x, longint lo, longint hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return longint'(x);
    endfunction

    function automatic out_item_t predict_motor_cmd(in_item_t req);
        out_item_t          cmd;
        logic signed [32:0] lc, rc, g, ng;
        logic signed [33:0] el, step;
        logic signed [49:0] acc;
        logic signed [31:0] err, rate;
        logic signed [67:0] corr, base;
        longint             ls, rs;
        cmd = '0;
        ls = 0;
        rs = 0;
        if (req.req_type == REQ_START) begin
            goal_cnt   = req.goal_pulses;
            run_mode   = req.move_mode;
            left_done  = 1'b0;
            right_done = 1'b0;
            if (run_mode == MODE_WALK) begin
                ls = walk_spd;
                rs = walk_spd;
            end
        end else if (left_done && right_done) begin
            cmd.move_finished = 1'b1;
        end else begin
            lc = req.left_count;
            rc = req.right_count;
            g  = goal_cnt;
            if (run_mode == MODE_WALK) begin
                err       = clamp(lc - rc, S32_MIN, S32_MAX);
                el        = {18'd0, req.elapsed_ms};
                acc       = integ_acc + err * el;
                integ_acc = clamp(acc, S32_MIN, S32_MAX);
                rate      = '0;
                if (el != 0) begin
                    step = (err - last_err) / el;
                    rate = clamp(step, S32_MIN, S32_MAX);
                end
                corr = $signed({1'b0, p_gain}) * err + $signed({1'b0, i_gain}) * integ_acc
                     + $signed({1'b0, d_gain}) * rate;
                corr = corr >>> 17;
                last_err = err;
                base = $signed({1'b0, walk_spd}) + corr;
                if (lc < g && g > 0)
                    ls = walk_spd;
                else if (lc > g && g < 0)
                    ls = -longint'(walk_spd);
                else
                    left_done = 1'b1;
                if (rc < g && g > 0)
                    rs = clamp(base, S16_MIN, S16_MAX);
                else if (rc > g && g < 0)
                    rs = clamp(-base, S16_MIN, S16_MAX);
                else
                    right_done = 1'b1;
            end else begin
                ng = -g;
                if (lc < g)
                    ls = turn_spd;
                else if (lc > g)
                    ls = -longint'(turn_spd);
                else
                    left_done = 1'b1;
                if (rc < ng)
                    rs = turn_spd;
                else if (rc > ng)
                    rs = -longint'(turn_spd);
                else
                    right_done = 1'b1;
            end
            if (left_done && right_done) begin
                cmd.move_finished = 1'b1;
                ls = 0;
                rs = 0;
            end
        end
        cmd.left_speed    = 16'(ls);
        cmd.right_speed   = 16'(rs);
        cmd.left_reached  = left_done;
        cmd.right_reached = right_done;
        return cmd;
    endfunction

    function automatic int check_field(string name, longint want, longint got);
        if (want == got) return 0;
        $error("%s: expected %0d, got %0d", name, want, got);
        return 1;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            p_gain     = PROP_GAIN_RST;
            i_gain     = INTEG_GAIN_RST;
            d_gain     = DERIV_GAIN_RST;
            walk_spd   = WALK_SPEED_RST;
            turn_spd   = TURN_SPEED_RST;
            integ_acc  = '0;
            last_err   = '0;
            goal_cnt   = '0;
            run_mode   = MODE_WALK;
            left_done  = 1'b1;
            right_done = 1'b1;
            cmd_due_q.delete();
        end else begin
            if (cfg_wen) begin
                case (cfg_index)
                    REG_PROP_GAIN:  p_gain   = cfg_wdata;
                    REG_INTEG_GAIN: i_gain   = cfg_wdata;
                    REG_DERIV_GAIN: d_gain   = cfg_wdata;
                    REG_WALK_SPEED: walk_spd = cfg_wdata[14:0];
                    REG_TURN_SPEED: turn_spd = cfg_wdata[14:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_data.move_finished)
                    moves_finished++;
                if (cmd_due_q.size() == 0) begin
                    $error("unexpected result: left_speed %0d right_speed %0d",
                           m_data.left_speed, m_data.right_speed);
                    mismatches++;
                end else begin
                    want = cmd_due_q.pop_front();
                    mismatches += check_field("left_speed", want.left_speed, m_data.left_speed);
                    mismatches += check_field("right_speed", want.right_speed,
                                              m_data.right_speed);
                    mismatches += check_field("left_reached", want.left_reached,
                                              m_data.left_reached);
                    mismatches += check_field("right_reached", want.right_reached,
                                              m_data.right_reached);
                    mismatches += check_field("move_finished", want.move_finished,
                                              m_data.move_finished);
                end
            end
            if (s_valid && s_ready)
                cmd_due_q.push_back(predict_motor_cmd(s_data));
        end
        cmds_due = cmd_due_q.size();
    end

endmodule

/* sim/two_wheel_encoder_move_pid_unit_tb.sv */
// Testbench top for two_wheel_encoder_move_pid_unit: drives start and tick items,
// programs gains and speeds, throttles both channels and reports the verdict.
// Depends on twemp_pkg, two_wheel_move_checker and the unit itself.
module two_wheel_encoder_move_pid_unit_tb import twemp_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_data;
    logic                   cfg_wen   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int   mismatches, cmds_due, results_seen, moves_finished;
    int   items_sent     = 0;
    int   moves_started  = 0;
    int   src_gap_pct    = 0;
    int   sink_stall_pct = 0;
    logic sink_hold      = 1'b0;

    two_wheel_encoder_move_pid_unit dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .cfg_wen, .cfg_index, .cfg_wdata
    );

    two_wheel_move_checker checker_i (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .cfg_wen, .cfg_index, .cfg_wdata, .mismatches, .cmds_due, .results_seen,
        .moves_finished
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= !sink_hold && ($urandom_range(0, 99) >= sink_stall_pct);
    end

    initial begin
        #5ms;
        $display("** two_wheel_encoder_move_pid_unit: FAILED **");
        $finish;
    end

    function automatic logic signed [31:0] clip32(longint x);
        if (x > 2147483647) return 32'sh7FFF_FFFF;
        if (x < -2147483648) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic in_item_t start_req(logic mode, logic signed [31:0] goal);
        in_item_t it;
        it.req_type    = REQ_START;
        it.move_mode   = mode;
        it.goal_pulses = goal;
        it.left_count  = $urandom;
        it.right_count = $urandom;
        it.elapsed_ms  = $urandom;
        return it;
    endfunction

    function automatic in_item_t tick_req(logic signed [31:0] lc, logic signed [31:0] rc,
                                          logic [15:0] el);
        in_item_t it;
        it.req_type    = REQ_TICK;
        it.move_mode   = $urandom;
        it.goal_pulses = $urandom;
        it.left_count  = lc;
        it.right_count = rc;
        it.elapsed_ms  = el;
        return it;
    endfunction

    function automatic in_item_t noise_req();
        in_item_t it;
        it.req_type    = $urandom;
        it.move_mode   = $urandom;
        it.goal_pulses = $urandom;
        it.left_count  = $urandom;
        it.right_count = $urandom;
        it.elapsed_ms  = $urandom;
        return it;
    endfunction

    function automatic logic [15:0] pick_elapsed();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) return 16'($urandom_range(1, 20));
        if (sel < 80) return '0;
        return 16'($urandom);
    endfunction

    function automatic longint approach(longint pos, longint tgt);
        if ($urandom_range(0, 9) == 0) return tgt;
        return pos + (tgt - pos) * longint'($urandom_range(0, 60)) / 100
             + longint'($urandom_range(0, 6)) - 3;
    endfunction

    task automatic send_req(in_item_t it);
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (cmds_due == 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic program_regs(logic [31:0] pg, logic [31:0] ig, logic [31:0] dg,
                                logic [14:0] ws, logic [14:0] ts);
        logic [CFG_DATA_W-1:0]  vals[5];
        logic [CFG_INDEX_W-1:0] idx[5];
        vals = '{pg, ig, dg, {17'd0, ws}, {17'd0, ts}};
        idx  = '{REG_PROP_GAIN, REG_INTEG_GAIN, REG_DERIV_GAIN, REG_WALK_SPEED,
                 REG_TURN_SPEED};
        for (int i = 0; i < 5; i++) begin
            @(negedge aclk);
            cfg_wen   <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
        end
        @(negedge aclk);
        cfg_wen <= 1'b0;
    endtask

    task automatic run_move();
        logic signed [31:0] g32;
        longint             goal, lt, rt, lpos, rpos;
        logic               mode;
        int                 n, sel;
        sel = $urandom_range(0, 99);
        g32 = $urandom;
        if (sel < 55)
            goal = $urandom_range(1, 3000);
        else if (sel < 70)
            goal = g32;
        else if (sel < 80)
            goal = 0;
        else
            goal = $urandom_range(1, 20);
        if (sel < 55 || sel >= 80)
            if ($urandom_range(0, 1)) goal = -goal;
        mode = $urandom;
        send_req(start_req(mode, goal[31:0]));
        moves_started++;
        lt   = goal;
        rt   = (mode == MODE_TURN) ? -goal : goal;
        lpos = 0;
        rpos = 0;
        n    = $urandom_range(2, 24);
        for (int i = 0; i < n; i++) begin
            lpos = approach(lpos, lt);
            rpos = approach(rpos, rt);
            if (i == n - 1 && $urandom_range(0, 1)) begin
                lpos = lt;
                rpos = rt;
            end
            send_req(tick_req(clip32(lpos), clip32(rpos), pick_elapsed()));
        end
    endtask

    task automatic random_traffic(int count);
        int stop;
        stop = items_sent + count;
        while (items_sent < stop) begin
            if ($urandom_range(0, 99) < 85)
                run_move();
            else
                send_req(noise_req());
        end
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // tick while idle, then walk forward to completion
        send_req(tick_req(0, 0, 0));
        send_req(start_req(MODE_WALK, 100));
        send_req(tick_req(0, 0, 0));
        send_req(tick_req(50, 40, 1));
        send_req(tick_req(100, 90, 16'hFFFF));
        send_req(tick_req(100, 100, 3));
        send_req(tick_req(7, 7, 7));
        // walk backward with saturating error in both directions
        send_req(start_req(MODE_WALK, -1000));
        send_req(tick_req(0, 0, 5));
        send_req(tick_req(32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF));
        send_req(tick_req(32'sh7FFF_FFFF, 32'sh8000_0000, 1));
        send_req(tick_req(-2000, -2000, 2));
        send_req(start_req(MODE_WALK, 0));
        send_req(tick_req(0, 0, 1));
        send_req(start_req(MODE_WALK, 32'sh8000_0000));
        send_req(tick_req(-5, 3, 0));
        // turn in place, including the goal whose negation needs 33 bits
        send_req(start_req(MODE_TURN, 32'sh7FFF_FFFF));
        send_req(tick_req(0, 0, 9));
        send_req(start_req(MODE_TURN, 32'sh8000_0000));
        send_req(tick_req(32'sh8000_0000, 32'sh7FFF_FFFF, 1));
        send_req(start_req(MODE_TURN, 500));
        send_req(tick_req(500, -500, 4));
        send_req(tick_req(600, -600, 4));
        random_traffic(150);
        wait_idle();

        src_gap_pct    = 74;
        sink_stall_pct = 0;
        program_regs('1, '1, '1, '1, '1);
        random_traffic(170);
        wait_idle();

        src_gap_pct    = 0;
        sink_stall_pct = 74;
        program_regs('0, '0, '0, '0, '0);
        random_traffic(170);
        wait_idle();

        src_gap_pct    = 21;
        sink_stall_pct = 21;
        program_regs($urandom, $urandom_range(0, 1 << 20), $urandom,
                     $urandom_range(0, 32767), $urandom_range(0, 32767));
        random_traffic(170);
        wait_idle();

        src_gap_pct    = 0;
        sink_stall_pct = 0;
        program_regs(PROP_GAIN_RST, INTEG_GAIN_RST, 32'd1 << 20, WALK_SPEED_RST,
                     TURN_SPEED_RST);
        // hold off the receiver while items keep coming
        fork
            begin
                @(posedge aclk);
                sink_hold = 1'b1;
                repeat (400) @(posedge aclk);
                sink_hold = 1'b0;
            end
            random_traffic(40);
        join
        random_traffic(130);
        wait_idle();
        repeat (50) @(posedge aclk);

        $display("Run covered %0d items in %0d random moves plus directed cases,",
                 items_sent, moves_started);
        $display("%0d results checked, %0d finished answers, five register settings.",
                 results_seen, moves_finished);
        if (mismatches == 0)
            $display("** two_wheel_encoder_move_pid_unit: PASSED **");
        else
            $display("** two_wheel_encoder_move_pid_unit: FAILED **");
        $finish;
    end

endmodule
